[src/b128dd_pkg.sv]
`default_nettype none

package b128dd_pkg;

    // Decimal register and field widths
    localparam int NUM_DIGITS     = 39;
    localparam int BCD_BITS       = NUM_DIGITS * 4;
    localparam int HALF_BITS      = 64;
    localparam int SIZE_BITS      = 8;
    localparam int COUNT_BITS     = 6;
    localparam int STEPS_PER_STG  = 8;
    localparam int DEF_INPUT_BITS = 128;
    localparam int MAX_INPUT_BITS = 2 * HALF_BITS;

    // Stream widths: value_low, value_high, buffer_size in; bcd, counts out
    localparam int IN_TDATA_BITS  = 2 * HALF_BITS + SIZE_BITS;
    localparam int OUT_TDATA_BITS = BCD_BITS + 2 * COUNT_BITS;

    // One double dabble step: double every digit, the new bit enters the units digit.
    // A digit of five or more is corrected by three and carries into the next digit.
    function automatic logic [BCD_BITS-1:0] dabble_step(
        input logic [BCD_BITS-1:0] bcd,
        input logic                bit_in
    );
        logic [BCD_BITS-1:0] res;
        logic                carry;
        logic [3:0]          adj;
        res   = '0;
        carry = bit_in;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            adj = (bcd[4*k +: 4] >= 4'd5) ? bcd[4*k +: 4] + 4'd3 : bcd[4*k +: 4];
            res[4*k +: 4] = {adj[2:0], carry};
            carry = adj[3];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[src/binary128_to_decimal_digits_core.sv]
`default_nettype none

// Unsigned binary to BCD converter, up to 128 bits, 39 decimal digits.
// Input stream s_*: one request per accepted beat carries the value halves
// and a destination buffer size. Output stream m_*: one result per request
// with the 39 BCD digits, the significant digit count (at least one) and
// the number of leading digits that fit in the buffer beside a terminator.
// Each dabble stage shifts in eight bits, then one stage counts digits and
// one clips to the buffer. A new request is taken every cycle while the
// receiver does not stall a waiting result.
// The whole pipeline moves on one enable; when the receiver holds
// m_tready low with a result waiting, every stage holds and s_tready drops
// in the same cycle, so nothing is lost or repeated. Bubbles are carried
// as invalid stages. Reset clears all valid bits; the pipe is empty after.
// Only the low INPUT_BITS bits of the value are converted.
module binary128_to_decimal_digits_core #(
    parameter int INPUT_BITS = b128dd_pkg::DEF_INPUT_BITS
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // value_low[63:0], value_high[127:64], buffer_size[135:128]
    input  wire logic [b128dd_pkg::IN_TDATA_BITS-1:0]   s_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // bcd_low[63:0], bcd_mid[127:64], bcd_top[155:128],
    // digit_count[161:156], copied_count[167:162]
    output logic [b128dd_pkg::OUT_TDATA_BITS-1:0]       m_tdata
);

    localparam int STG  = b128dd_pkg::STEPS_PER_STG;
    localparam int NSTG = (INPUT_BITS + STG - 1) / STG;
    localparam int PAD  = NSTG * STG;
    localparam logic [PAD-1:0] VAL_MASK = {PAD{1'b1}} >> (PAD - INPUT_BITS);

    logic                                  en;
    logic [PAD-1:0]                        val_s  [0:NSTG-1];
    logic                                  vld_s  [0:NSTG];
    logic [b128dd_pkg::BCD_BITS-1:0]       bcd_s  [0:NSTG];
    logic [b128dd_pkg::SIZE_BITS-1:0]      size_s [0:NSTG];

    logic                                  out_vld;
    logic [b128dd_pkg::BCD_BITS-1:0]       out_bcd;
    logic [b128dd_pkg::COUNT_BITS-1:0]     out_digits;
    logic [b128dd_pkg::COUNT_BITS-1:0]     out_copied;

    // Hold the whole pipe only while a result waits on a stalled receiver
    assign en       = !out_vld || m_tready;
    assign s_tready = en;

    // Unpack request; high unused value bits are dropped
    assign val_s[0]  = s_tdata[PAD-1:0] & VAL_MASK;
    assign vld_s[0]  = s_tvalid;
    assign bcd_s[0]  = '0;
    assign size_s[0] = s_tdata[2*b128dd_pkg::HALF_BITS +: b128dd_pkg::SIZE_BITS];

    // Carry the unconsumed value bits along the stages
    for (genvar i = 0; i < NSTG - 1; i++) begin : g_val
        logic [PAD-1:0] val_reg;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                val_reg <= val_s[i] << STG;
            end
        end
        assign val_s[i+1] = val_reg;
    end

    // Dabble stages, eight bits each
    for (genvar i = 0; i < NSTG; i++) begin : g_stg
        b128dd_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (vld_s[i]),
            .in_chunk (val_s[i][PAD-1 -: STG]),
            .in_bcd   (bcd_s[i]),
            .in_size  (size_s[i]),
            .out_vld  (vld_s[i+1]),
            .out_bcd  (bcd_s[i+1]),
            .out_size (size_s[i+1])
        );
    end

    // Count digits and clip to buffer
    b128dd_count u_count (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_vld     (vld_s[NSTG]),
        .in_bcd     (bcd_s[NSTG]),
        .in_size    (size_s[NSTG]),
        .out_vld    (out_vld),
        .out_bcd    (out_bcd),
        .out_digits (out_digits),
        .out_copied (out_copied)
    );

    assign m_tvalid = out_vld;
    assign m_tdata  = {out_copied, out_digits, out_bcd};

endmodule

`default_nettype wire

[src/b128dd_stage.sv]
`default_nettype none

module b128dd_stage (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_vld,
    input  wire logic [b128dd_pkg::STEPS_PER_STG-1:0] in_chunk,
    input  wire logic [b128dd_pkg::BCD_BITS-1:0]   in_bcd,
    input  wire logic [b128dd_pkg::SIZE_BITS-1:0]  in_size,
    output logic                                   out_vld,
    output logic [b128dd_pkg::BCD_BITS-1:0]        out_bcd,
    output logic [b128dd_pkg::SIZE_BITS-1:0]       out_size
);

    logic                                vld_reg;
    logic [b128dd_pkg::BCD_BITS-1:0]     bcd_reg;
    logic [b128dd_pkg::BCD_BITS-1:0]     bcd_next;
    logic [b128dd_pkg::SIZE_BITS-1:0]    size_reg;

    // Shift in this stage's bits, most significant first
    always_comb
    begin
        bcd_next = in_bcd;
        for (int i = 0; i < b128dd_pkg::STEPS_PER_STG; i++)
        begin
            bcd_next = b128dd_pkg::dabble_step(bcd_next,
                                               in_chunk[b128dd_pkg::STEPS_PER_STG-1-i]);
        end
    end

    // Advance valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bcd_reg  <= bcd_next;
            size_reg <= in_size;
        end
    end

    assign out_vld  = vld_reg;
    assign out_bcd  = bcd_reg;
    assign out_size = size_reg;

endmodule

`default_nettype wire

[src/b128dd_count.sv]
`default_nettype none

module b128dd_count (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_vld,
    input  wire logic [b128dd_pkg::BCD_BITS-1:0]   in_bcd,
    input  wire logic [b128dd_pkg::SIZE_BITS-1:0]  in_size,
    output logic                                   out_vld,
    output logic [b128dd_pkg::BCD_BITS-1:0]        out_bcd,
    output logic [b128dd_pkg::COUNT_BITS-1:0]      out_digits,
    output logic [b128dd_pkg::COUNT_BITS-1:0]      out_copied
);

    logic                                 c_vld_reg;
    logic [b128dd_pkg::BCD_BITS-1:0]      c_bcd_reg;
    logic [b128dd_pkg::COUNT_BITS-1:0]    c_cnt_reg;
    logic [b128dd_pkg::COUNT_BITS-1:0]    c_cnt_next;
    logic [b128dd_pkg::SIZE_BITS-1:0]     c_size_reg;

    logic                                 o_vld_reg;
    logic [b128dd_pkg::BCD_BITS-1:0]      o_bcd_reg;
    logic [b128dd_pkg::COUNT_BITS-1:0]    o_cnt_reg;
    logic [b128dd_pkg::COUNT_BITS-1:0]    o_copy_reg;
    logic [b128dd_pkg::COUNT_BITS-1:0]    o_copy_next;
    logic [b128dd_pkg::SIZE_BITS-1:0]     room;

    // Find highest nonzero digit; zero keeps one digit
    always_comb
    begin
        c_cnt_next = b128dd_pkg::COUNT_BITS'(1);
        for (int k = 0; k < b128dd_pkg::NUM_DIGITS; k++)
        begin
            if (in_bcd[4*k +: 4] != 4'd0)
            begin
                c_cnt_next = b128dd_pkg::COUNT_BITS'(k + 1);
            end
        end
    end

    // Clip to buffer room, one place kept for the terminator
    always_comb
    begin
        room = c_size_reg - b128dd_pkg::SIZE_BITS'(1);
        if (c_size_reg == '0)
        begin
            o_copy_next = '0;
        end
        else if ({2'b00, c_cnt_reg} < room)
        begin
            o_copy_next = c_cnt_reg;
        end
        else
        begin
            o_copy_next = room[b128dd_pkg::COUNT_BITS-1:0];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            c_vld_reg <= in_vld;
            o_vld_reg <= c_vld_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_bcd_reg  <= in_bcd;
            c_cnt_reg  <= c_cnt_next;
            c_size_reg <= in_size;
            o_bcd_reg  <= c_bcd_reg;
            o_cnt_reg  <= c_cnt_reg;
            o_copy_reg <= o_copy_next;
        end
    end

    assign out_vld    = o_vld_reg;
    assign out_bcd    = o_bcd_reg;
    assign out_digits = o_cnt_reg;
    assign out_copied = o_copy_reg;

endmodule

`default_nettype wire

[src/b128dd_checker.sv]
`default_nettype none

module b128dd_checker (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tready,
    input  wire logic                                   m_tvalid,
    input  wire logic                                   m_tready,
    input  wire logic [b128dd_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);

    localparam int CNT_LO  = b128dd_pkg::BCD_BITS;
    localparam int COPY_LO = b128dd_pkg::BCD_BITS + b128dd_pkg::COUNT_BITS;

    logic [b128dd_pkg::COUNT_BITS-1:0] digits;
    logic [b128dd_pkg::COUNT_BITS-1:0] copied;

    assign digits = m_tdata[CNT_LO  +: b128dd_pkg::COUNT_BITS];
    assign copied = m_tdata[COPY_LO +: b128dd_pkg::COUNT_BITS];

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Input is refused exactly while a result waits on a stalled receiver
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");

    // Digit count stays within the decimal register
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> digits != '0 && digits <= b128dd_pkg::COUNT_BITS'(b128dd_pkg::NUM_DIGITS))
        else $error("digit count out of range");

    // Copied digits never exceed significant digits
    a_copied: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> copied <= digits)
        else $error("copied count exceeds digit count");

    // Top digit above the count is zero
    a_lead: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && digits != b128dd_pkg::COUNT_BITS'(b128dd_pkg::NUM_DIGITS)
        |-> m_tdata[b128dd_pkg::BCD_BITS-1 -: 4] == 4'd0)
        else $error("nonzero leading digit beyond count");

endmodule

bind binary128_to_decimal_digits_core b128dd_checker u_b128dd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
